[hw/rtl/max_pool_2d_with_argmax_unit_assert.svh]
// Assertion helpers shared by the pooling unit's RTL.
`ifndef MAX_POOL_2D_WITH_ARGMAX_UNIT_ASSERT_SVH
`define MAX_POOL_2D_WITH_ARGMAX_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is held
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/mp2d_pkg.sv]
package mp2d_pkg;

    // Fixed field widths
    localparam int OFF_BITS       = 3;
    localparam int IDX_BITS       = 10;
    localparam int WIN_CFG_BITS   = 4;
    localparam int PLANE_CFG_BITS = 11;
    localparam int CFG_DATA_BITS  = 11;
    localparam int REG_IDX_BITS   = 2;

    // Register map
    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_WINDOW_H     = 2'd0,
        REG_WINDOW_W     = 2'd1,
        REG_PLANE_WIDTH  = 2'd2,
        REG_PLANE_HEIGHT = 2'd3
    } reg_index_t;

    // Position of a maximum inside its window
    typedef struct packed {
        logic [OFF_BITS-1:0] row;
        logic [OFF_BITS-1:0] col;
    } offset_t;

    // Control carried with a row segment into the line merge
    typedef struct packed {
        logic                first_row;
        logic                emit;
        logic                last;
        logic [IDX_BITS-1:0] out_row;
        logic [IDX_BITS-1:0] out_col;
    } seg_tag_t;

endpackage

[hw/rtl/mp2d_line_merge.sv]
`include "max_pool_2d_with_argmax_unit_assert.svh"

// Partial-maximum line: one entry per output column. A finished row segment
// reads its column entry into a register, merges against it and writes back.
module mp2d_line_merge #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_WIDTH   = 1024,
    localparam int ADDR_BITS  = $clog2(MAX_WIDTH)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          seg_issue,
    input  logic [ADDR_BITS-1:0]          seg_addr,
    input  mp2d_pkg::seg_tag_t            seg_tag,
    input  logic signed [SAMPLE_BITS-1:0] seg_value,
    input  mp2d_pkg::offset_t             seg_off,
    input  logic                          seg_advance,
    output logic                          res_valid,
    output mp2d_pkg::seg_tag_t            res_tag,
    output logic signed [SAMPLE_BITS-1:0] res_value,
    output mp2d_pkg::offset_t             res_off
);

    localparam int WORD_BITS = SAMPLE_BITS + $bits(mp2d_pkg::offset_t);

    logic [WORD_BITS-1:0] line_mem [MAX_WIDTH];

    logic                          st_valid_reg, st_valid_next;
    logic                          fwd_reg, fwd_next;
    logic [ADDR_BITS-1:0]          st_addr_reg;
    mp2d_pkg::seg_tag_t            st_tag_reg;
    logic signed [SAMPLE_BITS-1:0] st_value_reg;
    mp2d_pkg::offset_t             st_off_reg;
    logic [WORD_BITS-1:0]          rd_word_reg;
    logic [WORD_BITS-1:0]          wb_word_reg;

    logic [WORD_BITS-1:0]          line_word;
    logic signed [SAMPLE_BITS-1:0] line_value;
    mp2d_pkg::offset_t             line_off;
    logic                          take_seg;
    logic                          wr_en;
    logic [WORD_BITS-1:0]          merged_word;

    // Merge: first row of a window overwrites, later rows win only if larger
    always_comb begin
        line_word  = fwd_reg ? wb_word_reg : rd_word_reg;
        line_value = line_word[WORD_BITS-1 -: SAMPLE_BITS];
        line_off   = line_word[$bits(mp2d_pkg::offset_t)-1:0];
        take_seg   = st_tag_reg.first_row || (st_value_reg > line_value);
        res_value  = take_seg ? st_value_reg : line_value;
        res_off    = take_seg ? st_off_reg : line_off;
        merged_word = {res_value, res_off};
        wr_en      = st_valid_reg && seg_advance;
        res_valid  = st_valid_reg && st_tag_reg.emit;
        res_tag    = st_tag_reg;
    end

    // Forward the write-back when the next read hits the same column
    always_comb begin
        st_valid_next = seg_advance ? seg_issue : st_valid_reg;
        fwd_next      = seg_advance ? (seg_issue && wr_en && (st_addr_reg == seg_addr))
                                    : fwd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            st_valid_reg <= st_valid_next;
            fwd_reg      <= fwd_next;
        end
    end

    // Segment payload
    always_ff @(posedge aclk) begin
        if (seg_issue) begin
            st_addr_reg  <= seg_addr;
            st_tag_reg   <= seg_tag;
            st_value_reg <= seg_value;
            st_off_reg   <= seg_off;
        end
        if (wr_en) begin
            wb_word_reg <= merged_word;
        end
    end

    // Line memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[st_addr_reg] <= merged_word;
        end
        if (seg_issue) begin
            rd_word_reg <= line_mem[seg_addr];
        end
    end

    `ASSERT_IMPLY(a_issue_needs_room, aclk, aresetn, seg_issue, seg_advance,
        "segment issued while the merge stage is held")
    `ASSERT_IMPLY(a_fwd_has_segment, aclk, aresetn, fwd_reg, st_valid_reg,
        "forward flag set with no segment in flight")
    `ASSERT_NEXT(a_held_segment_stays, aclk, aresetn, st_valid_reg && !seg_advance,
        st_valid_reg && $stable(st_addr_reg), "held segment lost or moved")

endmodule

[hw/rtl/max_pool_2d_with_argmax_unit.sv]
// A window's result reaches m_valid through the merge stage register and then the output register.
// Throughput: one sample per cycle while s_ready is high, set by the line read-modify-write,
// whose registered read is covered by forwarding the previous write-back.
// Input stalls only while a result is ready, the output register is full and m_ready is low.
// Reset (aresetn, synchronous, active low) clears counters, running maximum and valid flags
// and restores the register defaults; the line memory is not cleared.
`include "max_pool_2d_with_argmax_unit_assert.svh"

module max_pool_2d_with_argmax_unit #(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_WINDOW  = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [mp2d_pkg::REG_IDX_BITS-1:0]     cfg_index,
    input  logic [mp2d_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [SAMPLE_BITS-1:0]         s_sample,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [SAMPLE_BITS-1:0]         m_max_value,
    output logic [mp2d_pkg::OFF_BITS-1:0]         m_max_row_off,
    output logic [mp2d_pkg::OFF_BITS-1:0]         m_max_col_off,
    output logic [mp2d_pkg::IDX_BITS-1:0]         m_out_row,
    output logic [mp2d_pkg::IDX_BITS-1:0]         m_out_col,
    output logic                                  m_last_in_plane
);

    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int PW    = $clog2(MAX_WINDOW + 1);
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int PRODW = CW + PW + 1;

    // Configuration registers
    logic [mp2d_pkg::WIN_CFG_BITS-1:0]   window_h_reg, window_w_reg;
    logic [mp2d_pkg::PLANE_CFG_BITS-1:0] plane_width_reg, plane_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_h_reg     <= mp2d_pkg::WIN_CFG_BITS'(2);
            window_w_reg     <= mp2d_pkg::WIN_CFG_BITS'(2);
            plane_width_reg  <= mp2d_pkg::PLANE_CFG_BITS'(28);
            plane_height_reg <= mp2d_pkg::PLANE_CFG_BITS'(28);
        end else if (cfg_wr_en) begin
            case (mp2d_pkg::reg_index_t'(cfg_index))
                mp2d_pkg::REG_WINDOW_H:
                    window_h_reg <= cfg_wdata[mp2d_pkg::WIN_CFG_BITS-1:0];
                mp2d_pkg::REG_WINDOW_W:
                    window_w_reg <= cfg_wdata[mp2d_pkg::WIN_CFG_BITS-1:0];
                mp2d_pkg::REG_PLANE_WIDTH:
                    plane_width_reg <= cfg_wdata[mp2d_pkg::PLANE_CFG_BITS-1:0];
                mp2d_pkg::REG_PLANE_HEIGHT:
                    plane_height_reg <= cfg_wdata[mp2d_pkg::PLANE_CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Effective sizes: zero acts as one, large values saturate
    logic [PW-1:0] wh, ww;
    logic [CW-1:0] pw, ph;

    always_comb begin
        if (window_h_reg == '0) begin
            wh = PW'(1);
        end else if (32'(window_h_reg) > MAX_WINDOW) begin
            wh = PW'(MAX_WINDOW);
        end else begin
            wh = PW'(window_h_reg);
        end
        if (window_w_reg == '0) begin
            ww = PW'(1);
        end else if (32'(window_w_reg) > MAX_WINDOW) begin
            ww = PW'(MAX_WINDOW);
        end else begin
            ww = PW'(window_w_reg);
        end
        if (plane_width_reg == '0) begin
            pw = CW'(1);
        end else if (32'(plane_width_reg) > MAX_WIDTH) begin
            pw = CW'(MAX_WIDTH);
        end else begin
            pw = CW'(plane_width_reg);
        end
        if (plane_height_reg == '0) begin
            ph = CW'(1);
        end else if (32'(plane_height_reg) > MAX_WIDTH) begin
            ph = CW'(MAX_WIDTH);
        end else begin
            ph = CW'(plane_height_reg);
        end
    end

    // Scan position
    logic [CW-1:0] col_cnt_reg, col_cnt_next;
    logic [CW-1:0] row_cnt_reg, row_cnt_next;
    logic [PW-1:0] cph_reg, cph_next;
    logic [PW-1:0] rph_reg, rph_next;
    logic [CW-1:0] win_col_reg, win_col_next;
    logic [CW-1:0] win_row_reg, win_row_next;

    logic signed [SAMPLE_BITS-1:0] rm_value_reg, rm_value_next;
    mp2d_pkg::offset_t             rm_off_reg, rm_off_next;

    logic s_fire;
    logic res_valid;
    mp2d_pkg::seg_tag_t            res_tag;
    logic signed [SAMPLE_BITS-1:0] res_value;
    mp2d_pkg::offset_t             res_off;

    assign s_ready = !(res_valid && m_valid && !m_ready);
    assign s_fire  = s_valid && s_ready;

    // Window bounds: the window must fit wholly inside the plane
    logic [PRODW-1:0] col_end, col_next_end, row_end, row_next_end;
    logic             active, last_win, seg_end, emit, take_sample;
    mp2d_pkg::seg_tag_t seg_tag;

    always_comb begin
        col_end      = (PRODW'(win_col_reg) + PRODW'(1)) * PRODW'(ww);
        col_next_end = col_end + PRODW'(ww);
        row_end      = (PRODW'(win_row_reg) + PRODW'(1)) * PRODW'(wh);
        row_next_end = row_end + PRODW'(wh);
        active   = (col_end <= PRODW'(pw)) && (row_end <= PRODW'(ph))
                   && (32'(win_col_reg) < MAX_WIDTH);
        last_win = (col_next_end > PRODW'(pw)) && (row_next_end > PRODW'(ph));
        seg_end  = active && (cph_reg >= ww - PW'(1));
        emit     = rph_reg >= wh - PW'(1);
        take_sample = (cph_reg == '0) || (s_sample > rm_value_reg);

        seg_tag.first_row = (rph_reg == '0);
        seg_tag.emit      = emit;
        seg_tag.last      = last_win;
        seg_tag.out_row   = mp2d_pkg::IDX_BITS'(win_row_reg);
        seg_tag.out_col   = mp2d_pkg::IDX_BITS'(win_col_reg);
    end

    // Row-segment maximum, first maximum kept on ties
    always_comb begin
        rm_value_next = rm_value_reg;
        rm_off_next   = rm_off_reg;
        if (active && take_sample) begin
            rm_value_next   = s_sample;
            rm_off_next.row = mp2d_pkg::OFF_BITS'(rph_reg);
            rm_off_next.col = mp2d_pkg::OFF_BITS'(cph_reg);
        end
    end

    // Raster counters, wrapping at window and plane edges
    always_comb begin
        col_cnt_next = col_cnt_reg + CW'(1);
        cph_next     = cph_reg + PW'(1);
        win_col_next = win_col_reg;
        row_cnt_next = row_cnt_reg;
        rph_next     = rph_reg;
        win_row_next = win_row_reg;
        if (cph_next >= ww) begin
            cph_next     = '0;
            win_col_next = win_col_reg + CW'(1);
        end
        if (col_cnt_next >= pw) begin
            col_cnt_next = '0;
            cph_next     = '0;
            win_col_next = '0;
            row_cnt_next = row_cnt_reg + CW'(1);
            rph_next     = rph_reg + PW'(1);
            if (rph_next >= wh) begin
                rph_next     = '0;
                win_row_next = win_row_reg + CW'(1);
            end
            if (row_cnt_next >= ph) begin
                row_cnt_next = '0;
                rph_next     = '0;
                win_row_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            cph_reg      <= '0;
            rph_reg      <= '0;
            win_col_reg  <= '0;
            win_row_reg  <= '0;
            rm_value_reg <= '0;
            rm_off_reg   <= '0;
        end else if (s_fire) begin
            col_cnt_reg  <= col_cnt_next;
            row_cnt_reg  <= row_cnt_next;
            cph_reg      <= cph_next;
            rph_reg      <= rph_next;
            win_col_reg  <= win_col_next;
            win_row_reg  <= win_row_next;
            rm_value_reg <= rm_value_next;
            rm_off_reg   <= rm_off_next;
        end
    end

    // Column line read-modify-write
    mp2d_line_merge #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_line (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .seg_issue   (s_fire && seg_end),
        .seg_addr    (win_col_reg[AW-1:0]),
        .seg_tag     (seg_tag),
        .seg_value   (rm_value_next),
        .seg_off     (rm_off_next),
        .seg_advance (s_ready),
        .res_valid   (res_valid),
        .res_tag     (res_tag),
        .res_value   (res_value),
        .res_off     (res_off)
    );

    // Output register
    logic m_valid_reg, m_valid_next;
    logic out_load;

    assign out_load     = res_valid && s_ready;
    assign m_valid_next = out_load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_max_value     <= res_value;
            m_max_row_off   <= res_off.row;
            m_max_col_off   <= res_off.col;
            m_out_row       <= res_tag.out_row;
            m_out_col       <= res_tag.out_col;
            m_last_in_plane <= res_tag.last;
        end
    end

    assign m_valid = m_valid_reg;

    `ASSERT_IMPLY(a_stall_only_when_blocked, aclk, aresetn, !s_ready,
        m_valid_reg && !m_ready && res_valid, "input stalled with the output free")
    `ASSERT_IMPLY(a_row_start_aligned, aclk, aresetn, col_cnt_reg == '0,
        (cph_reg == '0) && (win_col_reg == '0), "window column state off at row start")
    `ASSERT_NEXT(a_result_reaches_output, aclk, aresetn, out_load, m_valid_reg,
        "window result not registered at the output")

endmodule
